// ===== sv/hbb_pkg.sv =====
// types, constants and helpers shared by the heightmap brush blend block
package hbb_pkg;

	localparam int H_W      = 16;
	localparam int GAIN_W   = 20;
	localparam int PROD_W   = 29;
	localparam int PMAG_W   = 28;
	localparam int DMAG_W   = 40;
	localparam int ACC_W    = 68;
	localparam int DIV_W    = 48;
	localparam int DIV_VW   = 17;
	localparam int VAL_W    = 51;
	localparam int MUL_STEPS = 28;

	localparam logic [GAIN_W-1:0] GAIN_RESET  = 20'd4096;
	localparam logic [H_W-1:0]    MAXH_RESET  = 16'hffff;
	localparam logic [16:0]       COUNT_MAX   = 17'h1ffff;

	typedef enum logic [1:0] {
		MODE_REL  = 2'd0,
		MODE_AVG  = 2'd1,
		MODE_ABS  = 2'd2,
		MODE_COPY = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_SCAN   = 2'd1,
		CMD_APPLY  = 2'd2,
		CMD_UNUSED = 2'd3
	} item_cmd_t;

	typedef enum logic [1:0] {
		CFG_MODE   = 2'd0,
		CFG_GAIN   = 2'd1,
		CFG_TARGET = 2'd2,
		CFG_MAXH   = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_DECIDE,
		ST_MEAN,
		ST_MUL,
		ST_QSTART,
		ST_QUO,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_HOLD,
		RES_REL,
		RES_MEAN,
		RES_DELTA
	} res_sel_t;

	typedef struct packed {
		logic [1:0]     cmd;
		logic [H_W-1:0] current_height;
		logic [H_W-1:0] source_height;
		logic [7:0]     mask_value;
	} src_item_t;

	typedef struct packed {
		logic [H_W-1:0] new_height;
		logic           changed;
	} res_item_t;

	typedef struct packed {
		logic     latch;
		logic     acc_clear;
		logic     acc_scan;
		logic     prod_load;
		logic     mean_go;
		logic     mul_load;
		logic     mul_step;
		logic     quo_go;
		res_sel_t res_sel;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  skip;
		logic  mean_sat;
		logic  div_done;
		logic  mul_last;
	} dp_stat_t;

	function automatic logic [H_W-1:0] clamp_height(input logic signed [VAL_W-1:0] v,
		input logic [H_W-1:0] mx);
		logic [H_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({35'b0, mx})) begin
			r = mx;
		end else begin
			r = v[H_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/hbb_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module hbb_div #(
	parameter int DW = 48,
	parameter int VW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quo,
	output logic [VW-1:0] rem
);

	localparam int CW = (DW > 1) ? $clog2(DW) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;

	logic [VW:0]   remw;
	logic [VW+1:0] sub;
	logic          ge;

	assign remw = {rem_q, quo_q[DW-1]};
	assign sub  = {1'b0, remw} - {2'b0, dsr_q};
	assign ge   = !sub[VW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? sub[VW-1:0] : remw[VW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && dsr_q != '0 |-> rem_q < dsr_q)
		else $error("remainder not below divisor");

endmodule

// ===== sv/hbb_dp.sv =====
// datapath: configuration, scan accumulators, shift-add multiplier, divider and result
module hbb_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [19:0]           cfg_data,
	input  hbb_pkg::src_item_t    src_item,
	input  hbb_pkg::ctrl_cmd_t    cmd,
	output hbb_pkg::dp_stat_t     stat,
	output hbb_pkg::res_item_t    res_item
);

	hbb_pkg::mode_t                  mode_q;
	logic signed [hbb_pkg::GAIN_W-1:0] gain_q;
	logic [15:0]                     target_q;
	logic [15:0]                     maxh_q;
	logic [31:0]                     sum_q;
	logic [16:0]                     count_q;
	logic [7:0]                      peak_q;

	logic [15:0]                     h_q;
	logic [15:0]                     s_q;
	logic [7:0]                      m_q;
	logic signed [hbb_pkg::PROD_W-1:0] p_q;
	logic [hbb_pkg::ACC_W-1:0]       mcand_q;
	logic [hbb_pkg::PMAG_W-1:0]      mplier_q;
	logic [hbb_pkg::ACC_W-1:0]       acc_q;
	logic [4:0]                      mcnt_q;
	logic                            neg_q;
	logic [15:0]                     res_q;
	hbb_pkg::res_item_t              out_q;

	logic [32:0]                     sum_ext;
	logic                            div_start;
	logic [hbb_pkg::DIV_W-1:0]       div_dividend;
	logic [hbb_pkg::DIV_VW-1:0]      div_divisor;
	logic                            div_done;
	logic [hbb_pkg::DIV_W-1:0]       quo;
	logic [hbb_pkg::DIV_VW-1:0]      rem;

	logic signed [40:0]              diff;
	logic [hbb_pkg::DMAG_W-1:0]      diff_mag;
	logic [hbb_pkg::PMAG_W-1:0]      p_mag;
	logic                            skip;
	logic                            sticky;
	logic                            round_up;
	logic [48:0]                     mag;
	logic signed [hbb_pkg::VAL_W-1:0] v_rel;
	logic signed [hbb_pkg::VAL_W-1:0] v_mean;
	logic signed [hbb_pkg::VAL_W-1:0] v_delta;
	logic [15:0]                     res_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= hbb_pkg::MODE_REL;
			gain_q   <= hbb_pkg::GAIN_RESET;
			target_q <= '0;
			maxh_q   <= hbb_pkg::MAXH_RESET;
			sum_q    <= '0;
			count_q  <= '0;
			peak_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (hbb_pkg::cfg_idx_t'(cfg_index))
					hbb_pkg::CFG_MODE:   mode_q   <= hbb_pkg::mode_t'(cfg_data[1:0]);
					hbb_pkg::CFG_GAIN:   gain_q   <= cfg_data;
					hbb_pkg::CFG_TARGET: target_q <= cfg_data[15:0];
					hbb_pkg::CFG_MAXH:   maxh_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.acc_clear) begin
				sum_q   <= '0;
				count_q <= '0;
				peak_q  <= '0;
			end else if (cmd.acc_scan && src_item.mask_value != 8'd0) begin
				sum_q <= sum_ext[32] ? 32'hffffffff : sum_ext[31:0];
				if (count_q != hbb_pkg::COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
				if (src_item.mask_value > peak_q) begin
					peak_q <= src_item.mask_value;
				end
			end
		end
	end

	assign sum_ext = {1'b0, sum_q} + {17'b0, src_item.current_height};

	// multiply and result registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			h_q <= src_item.current_height;
			s_q <= src_item.source_height;
			m_q <= src_item.mask_value;
		end
		if (cmd.prod_load) begin
			p_q <= gain_q * $signed({1'b0, m_q});
		end
		if (cmd.mul_load) begin
			mcand_q  <= {28'b0, diff_mag};
			mplier_q <= p_mag;
			acc_q    <= '0;
			mcnt_q   <= '0;
			neg_q    <= diff[40] ^ p_q[hbb_pkg::PROD_W-1];
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[hbb_pkg::ACC_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[hbb_pkg::PMAG_W-1:1]};
			mcnt_q   <= mcnt_q + 1'b1;
		end
		if (cmd.res_sel != hbb_pkg::RES_NONE) begin
			res_q <= res_next;
		end
		if (cmd.out_load) begin
			out_q.new_height <= res_q;
			out_q.changed    <= (res_q != h_q);
		end
	end

	assign div_start    = cmd.mean_go | cmd.quo_go;
	assign div_dividend = cmd.mean_go ? {8'b0, sum_q, 8'b0} :
		(mode_q == hbb_pkg::MODE_AVG ? acc_q[67:20] : acc_q[59:12]);
	assign div_divisor  = cmd.mean_go ? count_q : {9'b0, peak_q};

	hbb_div #(
		.DW(hbb_pkg::DIV_W),
		.VW(hbb_pkg::DIV_VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	always_comb begin
		unique case (mode_q)
			hbb_pkg::MODE_AVG:
				diff = $signed({1'b0, quo[39:0]}) - $signed({17'b0, h_q, 8'b0});
			hbb_pkg::MODE_ABS:
				diff = $signed({25'b0, target_q}) - $signed({25'b0, h_q});
			default:
				diff = $signed({25'b0, s_q}) - $signed({25'b0, h_q});
		endcase
		unique case (mode_q)
			hbb_pkg::MODE_AVG:
				skip = m_q == 8'd0 || gain_q == '0 || count_q == '0 || peak_q == 8'd0;
			hbb_pkg::MODE_ABS:
				skip = m_q == 8'd0 || gain_q == '0 || peak_q == 8'd0;
			default:
				skip = m_q == 8'd0 || peak_q == 8'd0;
		endcase
	end

	assign diff_mag = diff[40] ? 40'(-diff) : diff[39:0];
	assign p_mag    = p_q[hbb_pkg::PROD_W-1] ? 28'(-p_q) : p_q[27:0];

	// floor for a negative quotient rounds the magnitude up, copy mode truncates
	assign sticky   = (mode_q == hbb_pkg::MODE_AVG) ? |acc_q[19:0] : |acc_q[11:0];
	assign round_up = neg_q && (rem != '0 || sticky) && mode_q != hbb_pkg::MODE_COPY;
	assign mag      = {1'b0, quo} + {48'b0, round_up};
	assign v_delta  = $signed({35'b0, h_q}) +
		(neg_q ? -$signed({2'b0, mag}) : $signed({2'b0, mag}));
	assign v_rel    = $signed({35'b0, h_q}) + hbb_pkg::VAL_W'(p_q >>> 12);
	assign v_mean   = $signed({19'b0, quo[39:8]});

	always_comb begin
		unique case (cmd.res_sel)
			hbb_pkg::RES_REL:   res_next = hbb_pkg::clamp_height(v_rel, maxh_q);
			hbb_pkg::RES_MEAN:  res_next = hbb_pkg::clamp_height(v_mean, maxh_q);
			hbb_pkg::RES_DELTA: res_next = (mode_q == hbb_pkg::MODE_COPY) ? v_delta[15:0] :
				hbb_pkg::clamp_height(v_delta, maxh_q);
			default:            res_next = h_q;
		endcase
	end

	assign stat.mode     = mode_q;
	assign stat.skip     = skip;
	assign stat.mean_sat = p_q >= $signed({9'b0, peak_q, 12'b0});
	assign stat.div_done = div_done;
	assign stat.mul_last = mcnt_q == 5'(hbb_pkg::MUL_STEPS - 1);
	assign res_item      = out_q;

	a_peak_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (peak_q == 8'd0))
		else $error("mask peak and pixel count disagree");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.acc_clear |=> count_q >= $past(count_q))
		else $error("pixel count dropped without clear");

endmodule

// ===== sv/hbb_ctrl.sv =====
// controller state machine sequencing clear, scan and apply items
module hbb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	input  logic [1:0]         src_cmd,
	output logic               src_stall,
	output logic               res_valid,
	input  logic               res_stall,
	input  hbb_pkg::dp_stat_t  stat,
	output hbb_pkg::ctrl_cmd_t cmd
);

	hbb_pkg::state_t state_q;
	hbb_pkg::state_t state_d;
	logic            res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hbb_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_sel = hbb_pkg::RES_NONE;
		unique case (state_q)
			hbb_pkg::ST_IDLE: begin
				if (src_valid) begin
					unique case (hbb_pkg::item_cmd_t'(src_cmd))
						hbb_pkg::CMD_CLEAR: cmd.acc_clear = 1'b1;
						hbb_pkg::CMD_SCAN:  cmd.acc_scan  = 1'b1;
						hbb_pkg::CMD_APPLY: begin
							cmd.latch = 1'b1;
							state_d   = hbb_pkg::ST_PROD;
						end
						default: ;
					endcase
				end
			end
			hbb_pkg::ST_PROD: begin
				cmd.prod_load = 1'b1;
				state_d       = hbb_pkg::ST_DECIDE;
			end
			hbb_pkg::ST_DECIDE: begin
				priority if (stat.mode == hbb_pkg::MODE_REL) begin
					cmd.res_sel = hbb_pkg::RES_REL;
					state_d     = hbb_pkg::ST_DONE;
				end else if (stat.skip) begin
					cmd.res_sel = hbb_pkg::RES_HOLD;
					state_d     = hbb_pkg::ST_DONE;
				end else if (stat.mode == hbb_pkg::MODE_AVG) begin
					cmd.mean_go = 1'b1;
					state_d     = hbb_pkg::ST_MEAN;
				end else begin
					cmd.mul_load = 1'b1;
					state_d      = hbb_pkg::ST_MUL;
				end
			end
			hbb_pkg::ST_MEAN: begin
				if (stat.div_done) begin
					if (stat.mean_sat) begin
						cmd.res_sel = hbb_pkg::RES_MEAN;
						state_d     = hbb_pkg::ST_DONE;
					end else begin
						cmd.mul_load = 1'b1;
						state_d      = hbb_pkg::ST_MUL;
					end
				end
			end
			hbb_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_last) begin
					state_d = hbb_pkg::ST_QSTART;
				end
			end
			hbb_pkg::ST_QSTART: begin
				cmd.quo_go = 1'b1;
				state_d    = hbb_pkg::ST_QUO;
			end
			hbb_pkg::ST_QUO: begin
				if (stat.div_done) begin
					cmd.res_sel = hbb_pkg::RES_DELTA;
					state_d     = hbb_pkg::ST_DONE;
				end
			end
			hbb_pkg::ST_DONE: begin
				if (!res_valid_q || !res_stall) begin
					cmd.out_load = 1'b1;
					state_d      = hbb_pkg::ST_IDLE;
				end
			end
			default: state_d = hbb_pkg::ST_IDLE;
		endcase
	end

	assign src_stall = (state_q != hbb_pkg::ST_IDLE);
	assign res_valid = res_valid_q;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == hbb_pkg::ST_DONE))
		else $error("result raised outside done state");

	a_one_result_per_apply: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == hbb_pkg::ST_IDLE)
		else $error("controller did not return to idle after result");

endmodule

// ===== sv/heightmap_brush_blend.sv =====
// top level of the heightmap brush blend block
// clear and scan items: taken without stalling the source, no result
// apply, relative mode or unchanged pixel: result set in the product and decide states, registered out from done
// apply, absolute and copy: 28-step shift-add multiply, then 48-step divide
// apply, average: 48-step mean divide ahead of the above; at full strength the mean is the result
// one item in flight, a stalled result delays the next; async reset clears accumulators
module heightmap_brush_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               src_valid,
	output logic               src_stall,
	input  hbb_pkg::src_item_t src_item,
	output logic               res_valid,
	input  logic               res_stall,
	output hbb_pkg::res_item_t res_item
);

	hbb_pkg::ctrl_cmd_t cmd;
	hbb_pkg::dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	hbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_cmd   (src_item.cmd),
		.src_stall (src_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	hbb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_item  (src_item),
		.cmd       (cmd),
		.stat      (stat),
		.res_item  (res_item)
	);

endmodule

// ===== tb/heightmap_brush_blend_tb.sv =====
// testbench for the heightmap brush blend block: directed and random items checked against a predictor
`timescale 1ns / 100ps

module heightmap_brush_blend_tb;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	hbb_pkg::src_item_t src_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	hbb_pkg::res_item_t res_item;

	hbb_pkg::mode_t    brush_mode;
	logic signed [19:0] brush_gain;
	logic [15:0]       target_h;
	logic [15:0]       max_h;
	logic [31:0]       height_sum;
	logic [16:0]       pixel_count;
	logic [7:0]        mask_peak;

	hbb_pkg::res_item_t pending_heights[$];
	int errors = 0;
	bit calm = 0;

	always #2 clk = ~clk;

	heightmap_brush_blend u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
	);

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q -= 1;
		return q;
	endfunction

	function automatic logic [15:0] clamp_to_max(longint v);
		if (v < 0) return 16'd0;
		if (v > longint'(max_h)) return max_h;
		return v[15:0];
	endfunction

	function automatic void predict_blend(hbb_pkg::src_item_t it);
		longint h, s, m, g, pk, mean8, v, d;
		logic [15:0] r;
		hbb_pkg::res_item_t e;
		h = it.current_height;
		s = it.source_height;
		m = it.mask_value;
		g = brush_gain;
		pk = mask_peak;
		r = it.current_height;
		case (it.cmd)
			hbb_pkg::CMD_CLEAR: begin
				height_sum = '0;
				pixel_count = '0;
				mask_peak = '0;
				return;
			end
			hbb_pkg::CMD_SCAN: begin
				if (m != 0) begin
					if (longint'(height_sum) + h > 64'hffffffff) height_sum = 32'hffffffff;
					else height_sum = height_sum + it.current_height;
					if (pixel_count != hbb_pkg::COUNT_MAX) pixel_count++;
					if (it.mask_value > mask_peak) mask_peak = it.mask_value;
				end
				return;
			end
			hbb_pkg::CMD_APPLY: begin
				case (brush_mode)
					hbb_pkg::MODE_REL: r = clamp_to_max(fdiv(h * 4096 + m * g, 4096));
					hbb_pkg::MODE_AVG: if (m != 0 && g != 0 && pixel_count != 0 && pk != 0) begin
						mean8 = (longint'(height_sum) * 256) / longint'(pixel_count);
						if (g * m >= 4096 * pk) r = clamp_to_max(fdiv(mean8, 256));
						else r = clamp_to_max(h + fdiv((mean8 - h * 256) * g * m, 4096 * 256 * pk));
					end
					hbb_pkg::MODE_ABS: if (m != 0 && g != 0 && pk != 0)
						r = clamp_to_max(h + fdiv((longint'(target_h) - h) * g * m, 4096 * pk));
					default: if (m != 0 && pk != 0) begin
						d = ((s - h) * g * m) / (4096 * pk);
						v = h + d;
						r = v[15:0];
					end
				endcase
				e.new_height = r;
				e.changed = (r != it.current_height);
				pending_heights.push_back(e);
			end
			default: ;
		endcase
	endfunction

	task automatic write_reg(hbb_pkg::cfg_idx_t idx, logic [19:0] val);
		src_valid <= 1'b0;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			hbb_pkg::CFG_MODE:   brush_mode = hbb_pkg::mode_t'(val[1:0]);
			hbb_pkg::CFG_GAIN:   brush_gain = val;
			hbb_pkg::CFG_TARGET: target_h = val[15:0];
			default:             max_h = val[15:0];
		endcase
	endtask

	task automatic send_item(hbb_pkg::item_cmd_t c, logic [15:0] h, logic [15:0] s,
		logic [7:0] m);
		hbb_pkg::src_item_t it;
		it = '{cmd: c, current_height: h, source_height: s, mask_value: m};
		if (!calm) while ($urandom_range(99) < 25) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= it;
		do @(posedge clk); while (src_stall);
		predict_blend(it);
	endtask

	task automatic drain();
		int n;
		src_valid <= 1'b0;
		n = 0;
		while (pending_heights.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (300) @(posedge clk);
	endtask

	always @(posedge clk) begin
		res_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);
		if (res_valid && !res_stall) begin
			if (pending_heights.size() == 0) begin
				$error("result with nothing expected: new_height %0d", res_item.new_height);
				errors++;
			end else begin
				hbb_pkg::res_item_t e;
				e = pending_heights.pop_front();
				if (res_item.new_height !== e.new_height) begin
					$error("new_height expected %0d actual %0d", e.new_height,
						res_item.new_height);
					errors++;
				end
				if (res_item.changed !== e.changed) begin
					$error("changed expected %0d actual %0d", e.changed, res_item.changed);
					errors++;
				end
			end
		end
	end

	task automatic random_region(int n, bit big_masks);
		logic [15:0] hs[$];
		logic [15:0] ss[$];
		logic [7:0] ms[$];
		logic [7:0] m;
		send_item(hbb_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
		for (int i = 0; i < n; i++) begin
			m = ($urandom_range(5) == 0) ? 8'd0 :
				(big_masks ? 8'($urandom) : 8'($urandom_range(1, 16)));
			hs.push_back(16'($urandom));
			ss.push_back(16'($urandom));
			ms.push_back(m);
			send_item(hbb_pkg::CMD_SCAN, hs[i], ss[i], m);
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				send_item(hbb_pkg::CMD_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom));
			send_item(hbb_pkg::CMD_APPLY, ($urandom_range(3) == 0) ? 16'($urandom) : hs[i],
				ss[i], ms[i]);
		end
	endtask

	task automatic random_config();
		int k;
		k = $urandom_range(5);
		write_reg(hbb_pkg::CFG_MODE, 20'($urandom_range(3)));
		case (k)
			0: write_reg(hbb_pkg::CFG_GAIN, 20'h80000);
			1: write_reg(hbb_pkg::CFG_GAIN, 20'h7ffff);
			2: write_reg(hbb_pkg::CFG_GAIN, 20'd0);
			3: write_reg(hbb_pkg::CFG_GAIN, 20'($signed($urandom_range(0, 16384)) - 8192));
			default: write_reg(hbb_pkg::CFG_GAIN, 20'($urandom));
		endcase
		write_reg(hbb_pkg::CFG_TARGET, 20'($urandom));
		write_reg(hbb_pkg::CFG_MAXH, 20'(($urandom_range(7) == 0) ? 16'd0 :
			($urandom_range(3) == 0) ? 16'($urandom) : 16'hffff));
	endtask

	task automatic test_directed();
		write_reg(hbb_pkg::CFG_MAXH, 20'hffff);
		for (int md = 0; md < 4; md++) begin
			write_reg(hbb_pkg::CFG_MODE, 20'(md));
			send_item(hbb_pkg::CMD_APPLY, 16'd1000, 16'd50, 8'd100);
		end
		drain();
		write_reg(hbb_pkg::CFG_MODE, 20'(hbb_pkg::MODE_REL));
		write_reg(hbb_pkg::CFG_GAIN, 20'h7ffff);
		send_item(hbb_pkg::CMD_APPLY, 16'hffff, 16'h0, 8'hff);
		send_item(hbb_pkg::CMD_UNUSED, 16'h1234, 16'h0, 8'h1);
		send_item(hbb_pkg::CMD_SCAN, 16'hffff, 16'hffff, 8'hff);
		send_item(hbb_pkg::CMD_SCAN, 16'h0, 16'h0, 8'h0);
		send_item(hbb_pkg::CMD_SCAN, 16'h0, 16'h0, 8'h01);
		drain();
		write_reg(hbb_pkg::CFG_GAIN, 20'h80000);
		write_reg(hbb_pkg::CFG_MAXH, 20'd0);
		send_item(hbb_pkg::CMD_APPLY, 16'h0, 16'hffff, 8'hff);
		send_item(hbb_pkg::CMD_APPLY, 16'h8000, 16'hffff, 8'h80);
		drain();
		for (int md = 1; md < 4; md++) begin
			write_reg(hbb_pkg::CFG_MODE, 20'(md));
			write_reg(hbb_pkg::CFG_MAXH, 20'h8000);
			write_reg(hbb_pkg::CFG_TARGET, 20'hffff);
			write_reg(hbb_pkg::CFG_GAIN, 20'h01000);
			send_item(hbb_pkg::CMD_APPLY, 16'h0, 16'hffff, 8'hff);
			send_item(hbb_pkg::CMD_APPLY, 16'h1234, 16'h0, 8'h0);
			write_reg(hbb_pkg::CFG_GAIN, 20'h0);
			send_item(hbb_pkg::CMD_APPLY, 16'h1234, 16'hffff, 8'h40);
			drain();
		end
	endtask

	task automatic test_random();
		for (int r = 0; r < 60; r++) begin
			random_config();
			calm = (r >= 20 && r < 26);
			random_region($urandom_range(3, 16), 1'($urandom_range(1)));
			drain();
		end
		calm = 0;
	endtask

	task automatic test_long_region();
		write_reg(hbb_pkg::CFG_MODE, 20'(hbb_pkg::MODE_AVG));
		write_reg(hbb_pkg::CFG_GAIN, 20'd2048);
		write_reg(hbb_pkg::CFG_MAXH, 20'hffff);
		send_item(hbb_pkg::CMD_CLEAR, 16'd0, 16'd0, 8'd0);
		calm = 1;
		for (int i = 0; i < 350; i++) send_item(hbb_pkg::CMD_SCAN, 16'hffff, 16'd0, 8'd9);
		calm = 0;
		for (int i = 0; i < 6; i++)
			send_item(hbb_pkg::CMD_APPLY, 16'($urandom), 16'($urandom),
				8'($urandom_range(1, 255)));
		drain();
	endtask

	initial begin
		brush_mode = hbb_pkg::MODE_REL;
		brush_gain = hbb_pkg::GAIN_RESET;
		target_h = '0;
		max_h = hbb_pkg::MAXH_RESET;
		height_sum = '0;
		pixel_count = '0;
		mask_peak = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_long_region();
		if (errors == 0 && pending_heights.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
